[rtl/core/gzhi_pkg.sv]
// Shared types and constants for the gyro zero offset and heading integrator.
package gzhi_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 23;
    localparam int HEADING_W = 32;

    // Zeroing: number of samples averaged, counter and sum widths
    localparam int               COUNT_W      = 4;
    localparam logic [COUNT_W-1:0] ZERO_SAMPLES = 4'd10;
    localparam int               SUM_W        = 20;

    // Divide by ten: floor(n / 10) == (n * 419431) >> 22 for n below 699050
    localparam int          DIV10_IN_W  = 19;
    localparam int          DIV10_SHIFT = 22;
    localparam logic [18:0] DIV10_MUL   = 19'd419431;

    // Delta magnitude fits 16 bits unsigned (at most 65535)
    localparam int MAG_W = 16;

    // Yaw rate: delta * 62500 / 1024 == delta * 15625 >> 8
    localparam int          RATE_SHIFT = 8;
    localparam logic [13:0] RATE_MUL   = 14'd15625;
    localparam int          RATE_MAG_W = 22;

    // Heading step: delta * 15625 / 15360 == ((delta * 3125) >> 10) / 3
    localparam int          HEAD_SHIFT = 10;
    localparam logic [11:0] HEAD_MUL   = 12'd3125;
    localparam int          HEAD_PRE_W = 18;

    // Divide by three: floor(n / 3) == (n * 174763) >> 19 for n below 524288
    localparam int          DIV3_SHIFT = 19;
    localparam logic [17:0] DIV3_MUL   = 18'd174763;
    localparam int          STEP_W     = 17;

    // What the second stage does with a request
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_CLEAR,
        MODE_INTEG
    } gzhi_mode_t;

    // First-to-second stage payload
    typedef struct packed {
        gzhi_mode_t              mode;
        logic                    neg;
        logic [RATE_MAG_W-1:0]   rate_mag;
        logic [HEAD_PRE_W-1:0]   head_pre;
    } gzhi_mid_t;

endpackage

[rtl/core/gyro_zero_offset_and_heading_integrator.sv]
// Gyro zero offset calibration and heading integration, three register stages.
// A request moves from the input register to the product register and then to the result register.
// Throughput: one request per cycle while out_stall is low; the input register, the product register and
// the result register each move independently, so bubbles collapse under stall.
// Reset (rst_n low, async): pipeline empties, zeroing restarts with 10 samples to
// take, offset sum, heading and yaw rate clear to zero.
module gyro_zero_offset_and_heading_integrator
    import gzhi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  sample,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        calibrated,
    output logic signed [RATE_W-1:0]    yaw_rate,
    output logic signed [HEADING_W-1:0] heading
);

    // Stage registers
    logic                     in_full_reg,   in_full_next;
    logic [SAMPLE_W-1:0]      sample_reg;
    logic                     mid_valid_reg, mid_valid_next;
    gzhi_mid_t                mid_reg,       mid_next;
    logic                     out_valid_reg, out_valid_next;

    // Calibration state
    logic                     running_reg,   running_next;
    logic [COUNT_W-1:0]       left_reg,      left_next;
    logic [SUM_W-1:0]         sum_reg,       sum_next;

    // Integration state, also the result payload
    logic                     cal_reg,       cal_next;
    logic [RATE_W-1:0]        rate_reg,      rate_next;
    logic [HEADING_W-1:0]     heading_reg,   heading_next;

    // Handshake
    logic out_free, mid_free, in_free, in_load, in_move, mid_move;

    // First stage datapath
    logic [SUM_W-1:0]              s_ext;
    logic [SUM_W-1:0]              sum_add;
    logic [SUM_W-1:0]              sum_abs;
    logic [DIV10_IN_W+18:0]        q_prod;
    logic [MAG_W-1:0]              q_mag;
    logic [SUM_W-1:0]              offset_new;
    logic [MAG_W:0]                delta;
    logic [MAG_W:0]                delta_abs;
    logic [MAG_W-1:0]              mag;
    logic [MAG_W+13:0]             rate_prod;
    logic [MAG_W+11:0]             head_prod;

    // Second stage datapath
    logic [HEAD_PRE_W+17:0]        div3_prod;
    logic [STEP_W-1:0]             step_mag;
    logic [HEADING_W-1:0]          step_ext;

    // Flow control: each stage advances when the next one is free or draining
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        mid_free = !mid_valid_reg || out_free;
        in_free  = !in_full_reg || mid_free;
        in_load  = in_valid && in_free;
        in_move  = in_full_reg && mid_free;
        mid_move = mid_valid_reg && out_free;

        in_full_next   = in_load ? 1'b1 : (in_move ? 1'b0 : in_full_reg);
        mid_valid_next = in_move ? 1'b1 : (mid_move ? 1'b0 : mid_valid_reg);
        out_valid_next = mid_move ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    assign in_stall = !in_free;

    // Zeroing sum, divide by ten toward zero, delta and constant products
    always_comb
    begin
        s_ext      = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
        sum_add    = sum_reg + s_ext;
        sum_abs    = sum_add[SUM_W-1] ? (~sum_add + 1'b1) : sum_add;
        q_prod     = (DIV10_IN_W+19)'(sum_abs[DIV10_IN_W-1:0]) * (DIV10_IN_W+19)'(DIV10_MUL);
        q_mag      = q_prod[DIV10_SHIFT +: MAG_W];
        offset_new = sum_add[SUM_W-1] ? (~SUM_W'(q_mag) + 1'b1) : SUM_W'(q_mag);

        delta      = {sample_reg[SAMPLE_W-1], sample_reg} - sum_reg[MAG_W:0];
        delta_abs  = delta[MAG_W] ? (~delta + 1'b1) : delta;
        mag        = delta_abs[MAG_W-1:0];
        rate_prod  = (MAG_W+14)'(mag) * (MAG_W+14)'(RATE_MUL);
        head_prod  = (MAG_W+12)'(mag) * (MAG_W+12)'(HEAD_MUL);

        running_next = running_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;

        mid_next.neg      = delta[MAG_W];
        mid_next.rate_mag = rate_prod[RATE_SHIFT +: RATE_MAG_W];
        mid_next.head_pre = head_prod[HEAD_SHIFT +: HEAD_PRE_W];
        mid_next.mode     = MODE_INTEG;

        if (!running_reg)
        begin
            left_next = left_reg - 1'b1;
            if (left_reg == COUNT_W'(1))
            begin
                sum_next      = offset_new;
                running_next  = 1'b1;
                mid_next.mode = MODE_CLEAR;
            end
            else
            begin
                sum_next      = sum_add;
                mid_next.mode = MODE_ZERO;
            end
        end
    end

    // Divide by three, apply sign, set calibrated and yaw rate, clear or accumulate heading by mode
    always_comb
    begin
        div3_prod = (HEAD_PRE_W+18)'(mid_reg.head_pre) * (HEAD_PRE_W+18)'(DIV3_MUL);
        step_mag  = div3_prod[DIV3_SHIFT +: STEP_W];
        step_ext  = mid_reg.neg ? (~HEADING_W'(step_mag) + 1'b1) : HEADING_W'(step_mag);

        cal_next     = cal_reg;
        rate_next    = rate_reg;
        heading_next = heading_reg;

        case (mid_reg.mode)
            MODE_ZERO:
            begin
                cal_next = 1'b0;
            end
            MODE_CLEAR:
            begin
                cal_next     = 1'b1;
                heading_next = '0;
            end
            MODE_INTEG:
            begin
                cal_next     = 1'b1;
                rate_next    = mid_reg.neg ? (~RATE_W'(mid_reg.rate_mag) + 1'b1)
                                           : RATE_W'(mid_reg.rate_mag);
                heading_next = heading_reg + step_ext;
            end
            default:
            begin
                cal_next = cal_reg;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            running_reg   <= 1'b0;
            left_reg      <= ZERO_SAMPLES;
            sum_reg       <= '0;
            cal_reg       <= 1'b0;
            rate_reg      <= '0;
            heading_reg   <= '0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_move)
            begin
                running_reg <= running_next;
                left_reg    <= left_next;
                sum_reg     <= sum_next;
            end
            if (mid_move)
            begin
                cal_reg     <= cal_next;
                rate_reg    <= rate_next;
                heading_reg <= heading_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            sample_reg <= sample;
        end
        if (in_move)
        begin
            mid_reg <= mid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign calibrated = cal_reg;
    assign yaw_rate   = rate_reg;
    assign heading    = heading_reg;

    // Once calibrated, the block never returns to zeroing
    a_running_holds: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |=> running_reg)
        else $error("calibration state fell back to zeroing");

    // While zeroing there is always at least one sample left to take
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (left_reg != '0))
        else $error("zeroing with no samples left");

    // Uncalibrated results carry zero rate and zero heading
    a_uncal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !cal_reg) |-> (rate_reg == '0 && heading_reg == '0))
        else $error("nonzero result before calibration");

    // Integration requests only follow the offset being formed
    a_integ_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && mid_reg.mode == MODE_INTEG) |-> running_reg)
        else $error("integration request while zeroing");

endmodule
